[src/circular_deque_defines.svh]
// ----------------------------------------------------------------------------
// circular_deque_defines
// Assertion macros used by the deque controller (dq_ctrl).
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define DQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Check that a condition implies another in the next cycle
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque sequence check failed");

`endif

[src/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the circular deque modules.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int WORD_W = 32;

    localparam logic [CNT_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    // Operation codes
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;

    // Register indexes
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
        logic [CNT_W-1:0]         count;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr_front;
        logic [ADDR_W-1:0] rd_addr_rear;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

[src/dq_ram.sv]
// ----------------------------------------------------------------------------
// dq_ram
// Ring store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module dq_ram
    import dq_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rd_front_data,
    output logic [WORD_W-1:0] rd_rear_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Register both read ports
    always_ff @(posedge aclk) begin
        rd_front_data <= mem[req.rd_addr_front];
        rd_rear_data  <= mem[req.rd_addr_rear];
    end

endmodule

[src/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// Head and count pointers, operation sequencer and result register.
// ----------------------------------------------------------------------------
`include "circular_deque_defines.svh"

module dq_ctrl
    import dq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  capacity,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    output mem_req_t          mem_req,
    input  logic [WORD_W-1:0] rd_front_data,
    input  logic [WORD_W-1:0] rd_rear_data
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ok_reg, ok_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic [CNT_W-1:0]  cap_eff;
    logic              full;
    logic              empty;
    logic              accept;
    logic              load_out;
    logic              empty_words;

    // Clamp the capacity to 1..DEPTH
    always_comb begin
        priority if (capacity == '0) begin
            cap_eff = CNT_W'(1);
        end else if (capacity > CNT_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = capacity;
        end
    end

    assign full    = (count_reg >= cap_eff);
    assign empty   = (count_reg == '0);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Apply the operation to the pointers and issue the store write
    always_comb begin
        head_next       = head_reg;
        count_next      = count_reg;
        ok_next         = ok_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = head_reg + count_reg[ADDR_W-1:0];
        mem_req.wr_data = s_data.value;
        // Read front and rear from the current pointers every cycle
        mem_req.rd_addr_front = head_reg;
        mem_req.rd_addr_rear  = head_reg + count_reg[ADDR_W-1:0] - ADDR_W'(1);
        if (accept) begin
            ok_next = 1'b1;
            unique case (s_data.mode)
                MODE_PUSH_FRONT: begin
                    if (full) begin
                        ok_next = 1'b0;
                    end else begin
                        head_next       = head_reg - ADDR_W'(1);
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = head_reg - ADDR_W'(1);
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                MODE_PUSH_BACK: begin
                    if (full) begin
                        ok_next = 1'b0;
                    end else begin
                        mem_req.wr_en = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                MODE_POP_FRONT: begin
                    if (empty) begin
                        ok_next = 1'b0;
                    end else begin
                        head_next  = head_reg + ADDR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_POP_BACK: begin
                    if (empty) begin
                        ok_next = 1'b0;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    // Peek and unused codes change nothing
                end
            endcase
        end
    end

    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Sequence: accept, read, then load the result register
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) begin
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_DONE: if (load_out) begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Build the result beat
    always_comb begin
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (load_out) begin
            m_valid_next           = 1'b1;
            m_data_next.ok         = ok_reg;
            m_data_next.is_empty   = empty;
            m_data_next.is_full    = full;
            m_data_next.count      = count_reg;
            m_data_next.front_value = empty ? EMPTY_WORD : rd_front_data;
            m_data_next.rear_value  = empty ? EMPTY_WORD : rd_rear_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the payload without reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign empty_words = (m_data_reg.front_value == EMPTY_WORD)
                      && (m_data_reg.rear_value == EMPTY_WORD);

    `DQ_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `DQ_ASSERT_IMPLY(a_push_room, aclk, aresetn, mem_req.wr_en, count_reg < CNT_W'(DEPTH))
    `DQ_ASSERT_NEXT(a_accept_read, aclk, aresetn, accept, state_reg == ST_READ)
    `DQ_ASSERT_IMPLY(a_empty_word, aclk, aresetn, m_valid_reg && m_data_reg.is_empty, empty_words)

endmodule

[src/circular_deque.sv]
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of 32-bit words in a ring store with a capacity register.
//
//   Channel   Direction  Handshake          Beat
//   s_        in         s_valid/s_ready    in_item_t  (mode, value)
//   m_        out        m_valid/m_ready    out_item_t (ok, front, rear, flags, count)
//   APB       in/out     psel/penable       capacity register at byte 0
//
// Each item passes through three steps: accept and write, store read, result load.
// The registered read data of the ring store sets the store read step.
// A new item is taken while the previous result still waits in m_data.
// A stalled m_ready holds the sequencer in its load step, with pointers held.
// Reset (aresetn low, synchronous) empties the deque and sets capacity to 16.
// ----------------------------------------------------------------------------
module circular_deque
    import dq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0]  capacity_reg, capacity_next;
    logic              reg_sel;
    mem_req_t          mem_req;
    logic [WORD_W-1:0] rd_front_data;
    logic [WORD_W-1:0] rd_rear_data;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_CAPACITY);

    // Write the capacity register
    always_comb begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            capacity_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    // Read back the register
    assign prdata = reg_sel ? {{(32-CNT_W){1'b0}}, capacity_reg} : '0;

    dq_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .capacity      (capacity_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .mem_req       (mem_req),
        .rd_front_data (rd_front_data),
        .rd_rear_data  (rd_rear_data)
    );

    dq_ram u_ram (
        .aclk          (aclk),
        .req           (mem_req),
        .rd_front_data (rd_front_data),
        .rd_rear_data  (rd_rear_data)
    );

endmodule

[bench/deque_result_checker.sv]
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches the operation, result and register ports of the circular deque.
// Keeps its own deque state, computes the result of every accepted operation
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module deque_result_checker
    import dq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    // Shadow deque state
    logic [WORD_W-1:0] ring [DEPTH];
    logic [ADDR_W-1:0] head;
    logic [CNT_W-1:0]  held;
    logic [CNT_W-1:0]  cap_reg;

    out_item_t predicted_results [$];

    // Clamp the register to the range the deque can honor
    function automatic logic [CNT_W-1:0] usable_capacity();
        if (cap_reg == '0)
            return CNT_W'(1);
        if (cap_reg > DEPTH)
            return CNT_W'(DEPTH);
        return cap_reg;
    endfunction

    // Apply one operation to the shadow deque and build its result
    function automatic out_item_t deque_apply(input in_item_t op);
        logic [CNT_W-1:0]  lim;
        logic [ADDR_W-1:0] slot;
        logic              done;
        out_item_t         r;
        lim  = usable_capacity();
        done = 1'b1;
        case (op.mode)
            MODE_PUSH_FRONT: begin
                if (held >= lim) begin
                    done = 1'b0;
                end else begin
                    head       = head - 1'b1;
                    ring[head] = op.value;
                    held       = held + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (held >= lim) begin
                    done = 1'b0;
                end else begin
                    slot       = head + held[ADDR_W-1:0];
                    ring[slot] = op.value;
                    held       = held + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (held == '0) begin
                    done = 1'b0;
                end else begin
                    head = head + 1'b1;
                    held = held - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (held == '0)
                    done = 1'b0;
                else
                    held = held - 1'b1;
            end
            default: ;  // peek and the unused codes change nothing
        endcase
        r.ok = done;
        if (held == '0) begin
            r.front_value = EMPTY_WORD;
            r.rear_value  = EMPTY_WORD;
        end else begin
            slot          = head + held[ADDR_W-1:0] - 1'b1;
            r.front_value = ring[head];
            r.rear_value  = ring[slot];
        end
        r.is_empty = (held == '0);
        r.is_full  = (held >= lim);
        r.count    = held;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("MISMATCH %s: got %h, predicted %h (result %0d)",
                 what, got, want, checked);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            head    = '0;
            held    = '0;
            cap_reg = CAP_RESET;
            for (int i = 0; i < DEPTH; i++)
                ring[i] = '0;
            predicted_results.delete();
            pending = 0;
        end else begin
            // Compare a result beat with the oldest prediction
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result beat with no operation pending", m_data.count, '0);
                end else begin
                    want = predicted_results.pop_front();
                    if (m_data.ok !== want.ok)
                        report_mismatch("ok", m_data.ok, want.ok);
                    if (m_data.front_value !== want.front_value)
                        report_mismatch("front_value", m_data.front_value, want.front_value);
                    if (m_data.rear_value !== want.rear_value)
                        report_mismatch("rear_value", m_data.rear_value, want.rear_value);
                    if (m_data.is_empty !== want.is_empty)
                        report_mismatch("is_empty", m_data.is_empty, want.is_empty);
                    if (m_data.is_full !== want.is_full)
                        report_mismatch("is_full", m_data.is_full, want.is_full);
                    if (m_data.count !== want.count)
                        report_mismatch("count", m_data.count, want.count);
                    checked++;
                end
            end
            // Track capacity writes; other addresses are ignored
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_CAPACITY)
                cap_reg = pwdata[CNT_W-1:0];
            // Predict the result of an accepted operation beat
            if (s_valid && s_ready)
                predicted_results.push_back(deque_apply(s_data));
            pending = predicted_results.size();
        end
    end

endmodule

[bench/circular_deque_tb.sv]
// ----------------------------------------------------------------------------
// circular_deque_tb
// Drives operations and capacity writes into the circular deque under several
// sender idle and receiver stall profiles; the result checker beside the block
// predicts every result and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module circular_deque_tb;
    import dq_pkg::*;

    localparam logic [2:0] MODE_PEEK       = 3'd4;
    localparam logic [2:0] ADDR_CAPACITY   = {REG_CAPACITY, 2'b00};
    localparam logic [2:0] ADDR_SPARE      = 3'b100;
    localparam int         PHASES          = 8;
    localparam int         OPS_PER_PHASE   = 222;
    localparam int         BIAS_RUN        = 40;
    localparam int         SETTLE_CYCLES   = 4;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int sent      = 0;
    int idle_pct  = 0;
    int stall_pct = 0;

    int send_idle  [4] = '{0, 83, 0, 20};
    int recv_stall [4] = '{0, 0, 83, 20};
    int phase_caps [PHASES] = '{16, 1, 5, 0, 31, 9, 2, 16};

    circular_deque uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    deque_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // 12-unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Abort a hung run
    initial begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

    // Register write: setup, then access until pready
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write capacity with random junk in the unused upper bits
    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        logic [31:0] w;
        w = $urandom;
        w[CNT_W-1:0] = cap;
        apb_write(ADDR_CAPACITY, w);
    endtask

    // Hold the sender until every predicted result has come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Offer one operation beat, idling first at the current rate
    task automatic send_op(input logic [2:0] mode, input logic [31:0] value);
        in_item_t beat;
        beat.mode  = mode;
        beat.value = value;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Mostly random words, now and then an extreme
    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Choose an operation; fill_bias sets the share of pushes among pushes and pops
    function automatic logic [2:0] pick_mode(input int fill_bias);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return MODE_PEEK + 3'($urandom_range(1, 3));
        if (r < 10)
            return MODE_PEEK;
        if ($urandom_range(99) < fill_bias)
            return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    initial begin
        int fill_bias;
        int cap;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty deque: failed pops, peek and the unused codes
        set_capacity(5'd16);
        send_op(MODE_PEEK, pick_word());
        send_op(MODE_POP_FRONT, pick_word());
        send_op(MODE_POP_BACK, pick_word());
        send_op(MODE_PEEK + 3'd1, 32'h1234_5678);
        send_op(MODE_PEEK + 3'd2, 32'hFFFF_FFFF);
        send_op(MODE_PEEK + 3'd3, 32'h0000_0000);
        // Push extremes at both ends, then pop them all
        send_op(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(MODE_PUSH_BACK, 32'h8000_0000);
        send_op(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(MODE_PUSH_BACK, 32'h0000_0000);
        send_op(MODE_PEEK, 32'h0000_0000);
        send_op(MODE_POP_BACK, 32'h0000_0000);
        send_op(MODE_POP_FRONT, 32'h0000_0000);
        send_op(MODE_POP_FRONT, 32'h0000_0000);
        send_op(MODE_POP_BACK, 32'h0000_0000);
        settle();

        // Small capacity: fill and reject pushes at both ends
        set_capacity(5'd2);
        send_op(MODE_PUSH_BACK, 32'h5555_5555);
        send_op(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
        send_op(MODE_PUSH_BACK, 32'h0000_0001);
        send_op(MODE_PUSH_FRONT, 32'h0000_0001);
        settle();

        // Capacity zero acts as one, now below the held count
        set_capacity(5'd0);
        send_op(MODE_PUSH_BACK, 32'h0BAD_F00D);
        send_op(MODE_POP_FRONT, 32'h0000_0000);
        send_op(MODE_PUSH_FRONT, 32'h0BAD_F00D);
        settle();

        // Oversized capacity saturates; a write to the spare address is dropped
        set_capacity(5'd31);
        apb_write(ADDR_SPARE, 32'h0000_0001);
        send_op(MODE_PUSH_FRONT, 32'hC0DE_0001);
        send_op(MODE_POP_BACK, 32'h0000_0000);
        send_op(MODE_POP_BACK, 32'h0000_0000);
        settle();

        // Random phases, each with its own capacity and idle profile
        fill_bias = 25;
        for (int ph = 0; ph < PHASES; ph++) begin
            cap = (ph == 5) ? $urandom_range(1, 15) : phase_caps[ph];
            if (ph == 3)
                apb_write(ADDR_SPARE, $urandom);
            set_capacity(cap[CNT_W-1:0]);
            idle_pct  = send_idle[ph % 4];
            stall_pct <= recv_stall[ph % 4];
            for (int n = 0; n < OPS_PER_PHASE; n++) begin
                // Alternate filling and draining runs so both ends are reached
                if (n % BIAS_RUN == 0)
                    fill_bias = (fill_bias > 50) ? 25 : 75;
                send_op(pick_mode(fill_bias), pick_word());
            end
            settle();
        end

        idle_pct  = 0;
        stall_pct <= 0;
        settle();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        $display("Summary: %0d operations over %0d random phases, %0d results checked,",
                 sent, PHASES, checked);
        $display("         capacities 0 to 31 written, idle and stall rates up to 83 percent");
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
